// File: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_BKSP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] KIND_PUT     = 3'd0;
    localparam logic [2:0] KIND_NEWLINE = 3'd1;
    localparam logic [2:0] KIND_BKSP    = 3'd2;
    localparam logic [2:0] KIND_CLEAR   = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0a;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  BLINK_BIT    = 8'h80;
    localparam logic [3:0]  RESET_COLOR  = 4'd7;
    localparam logic [15:0] RESET_BLANK  = {4'h0, RESET_COLOR, SPACE_CODE};

    typedef struct packed {
        logic [2:0]        kind;
        logic              oor;   // read index beyond the store
        logic [CELL_W-1:0] word;  // cell to write, or read index
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor;
        logic [CELL_W-1:0] data;
    } res_t;

endpackage

// File: rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tcw_queue.sv
module tcw_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/tcw_front.sv
module tcw_front #(
    parameter int CELLS = 2000
) (
    input  logic                     init_busy,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               op,
    input  logic [7:0]               char_code,
    input  logic [7:0]               attr,
    input  logic [7:0]               blink_char,
    input  logic [tcw_pkg::IDX_W-1:0] cell_index,
    input  logic                     q_full,
    output logic                     q_push,
    output tcw_pkg::cmd_t            cmd
);

    logic [7:0] attr_eff;

    // no words taken while the store is being cleared after reset
    assign full   = q_full || init_busy;
    assign q_push = push && !full;

    assign attr_eff = (char_code == blink_char) ? (attr | tcw_pkg::BLINK_BIT) : attr;

    always_comb
    begin
        cmd.oor  = 1'b0;
        cmd.word = {attr_eff, char_code};
        case (op)
            tcw_pkg::OP_PUT:
            begin
                cmd.kind = (char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::KIND_NEWLINE
                                                                 : tcw_pkg::KIND_PUT;
            end
            tcw_pkg::OP_BKSP:
            begin
                cmd.kind = tcw_pkg::KIND_BKSP;
            end
            tcw_pkg::OP_CLEAR:
            begin
                cmd.kind = tcw_pkg::KIND_CLEAR;
            end
            default:
            begin
                cmd.kind = tcw_pkg::KIND_READ;
                cmd.oor  = (32'(cell_index) >= CELLS);
                cmd.word = tcw_pkg::CELL_W'(cell_index);
            end
        endcase
    end

endmodule

// File: rtl/tcw_back.sv
module tcw_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    blank_color,
    input  tcw_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output tcw_pkg::res_t res,
    output logic          init_busy
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);
    localparam int XW    = (AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W;

    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [AW-1:0] LAST_BASE = AW'(CELLS - COLS);
    localparam logic [AW-1:0] CELL_MAX  = AW'(CELLS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] rowbase_reg, rowbase_next;
    logic [CW-1:0] col_reg, col_next;
    logic [3:0]    color_reg;
    logic          oor_reg, oor_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata, blank;
    logic [tcw_pkg::CELL_W-1:0] res_data;
    logic [XW-1:0]             cursor_ext;

    assign cfg_ready  = 1'b1;
    assign init_busy  = (state_reg == S_INIT);
    assign blank      = {4'h0, color_reg, tcw_pkg::SPACE_CODE};
    assign cmd_pop    = (state_reg == S_IDLE) && !cmd_empty && !res_full;
    assign cursor_ext = XW'(cursor_next);
    assign res        = {cursor_ext[tcw_pkg::IDX_W-1:0], res_data};

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cursor_next  = cursor_reg;
        rowbase_next = rowbase_reg;
        col_next     = col_reg;
        oor_next     = oor_reg;
        ram_we       = 1'b0;
        ram_waddr    = cursor_reg;
        ram_wdata    = blank;
        ram_raddr    = '0;
        res_push     = 1'b0;
        res_data     = '0;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = (state_reg == S_INIT) ? tcw_pkg::RESET_BLANK : blank;
                if (cnt_reg == CELL_MAX)
                begin
                    res_push   = (state_reg == S_CLEAR);
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        tcw_pkg::KIND_PUT, tcw_pkg::KIND_NEWLINE:
                        begin
                            if (cmd.kind == tcw_pkg::KIND_PUT)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = cmd.word;
                            end
                            if (cmd.kind == tcw_pkg::KIND_PUT && col_reg != LAST_COL)
                            begin
                                cursor_next = cursor_reg + 1'b1;
                                col_next    = col_reg + 1'b1;
                                res_push    = 1'b1;
                            end
                            else if (rowbase_reg == LAST_BASE)
                            begin
                                // past the bottom row: scroll, result when done
                                cursor_next = LAST_BASE;
                                col_next    = '0;
                                cnt_next    = '0;
                                state_next  = S_SCROLL;
                            end
                            else
                            begin
                                rowbase_next = rowbase_reg + COLS_A;
                                cursor_next  = rowbase_reg + COLS_A;
                                col_next     = '0;
                                res_push     = 1'b1;
                            end
                        end
                        tcw_pkg::KIND_BKSP:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                                if (col_reg == '0)
                                begin
                                    col_next     = LAST_COL;
                                    rowbase_next = rowbase_reg - COLS_A;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                            ram_we    = 1'b1;
                            ram_waddr = cursor_next;
                            res_push  = 1'b1;
                        end
                        tcw_pkg::KIND_CLEAR:
                        begin
                            cursor_next  = '0;
                            rowbase_next = '0;
                            col_next     = '0;
                            cnt_next     = '0;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            ram_raddr  = cmd.word[AW-1:0];
                            oor_next   = cmd.oor;
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_data   = oor_reg ? '0 : ram_rdata;
                res_push   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // read row below at cnt, write the word read last cycle one row up
                if (cnt_reg != LAST_BASE)
                begin
                    ram_raddr = cnt_reg + COLS_A;
                end
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == LAST_BASE)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == CELL_MAX)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            cnt_reg     <= '0;
            cursor_reg  <= '0;
            rowbase_reg <= '0;
            col_reg     <= '0;
            oor_reg     <= 1'b0;
            color_reg   <= tcw_pkg::RESET_COLOR;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cursor_reg  <= cursor_next;
            rowbase_reg <= rowbase_next;
            col_reg     <= col_next;
            oor_reg     <= oor_next;
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= blank_color;
            end
        end
    end

endmodule

// File: rtl/text_console_writer_top.sv
// Character-cell console writer: a COLS x ROWS screen store and a cursor.
// Input words enter through push/full: op, char_code, attr, blink_char,
// cell_index. One result word per input leaves through empty/pop:
// cursor_index after the op, and cell_data for a cell read (else 0).
// blank_color is written over cfg_valid/cfg_ready (always ready); the user
// must write it only while the block is idle: the block does not enforce it.
// Input words pass through a two-word command queue into the executor,
// which owns the screen RAM (one write and one registered read a cycle).
// Put character and backspace are done in the idle state as the word is
// popped; a read goes on to a read state for the registered RAM word. A
// clear sweeps every cell before its result; a scroll moves the store up
// one row and then blanks the bottom row before its result. No new word is
// popped until a read, clear or scroll is done.
// After reset full stays high while the store is filled with blanks.
// Results wait in a two-word queue; when it is full and pop stays low
// the executor stops and the command queue backs up to full.
module text_console_writer_top #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [3:0]                 blank_color,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 op,
    input  logic [7:0]                 char_code,
    input  logic [7:0]                 attr,
    input  logic [7:0]                 blink_char,
    input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
    output logic                       empty,
    input  logic                       pop,
    output logic [tcw_pkg::IDX_W-1:0]  cursor_index,
    output logic [tcw_pkg::CELL_W-1:0] cell_data
);

    tcw_pkg::cmd_t cmd_in, cmd_out;
    tcw_pkg::res_t res_in, res_out;
    logic          cq_push, cq_full, cq_pop, cq_empty;
    logic          rq_push, rq_full;
    logic          init_busy;

    tcw_front #(
        .CELLS (COLS * ROWS)
    ) u_front (
        .init_busy  (init_busy),
        .push       (push),
        .full       (full),
        .op         (op),
        .char_code  (char_code),
        .attr       (attr),
        .blink_char (blink_char),
        .cell_index (cell_index),
        .q_full     (cq_full),
        .q_push     (cq_push),
        .cmd        (cmd_in)
    );

    tcw_queue #(
        .W     ($bits(tcw_pkg::cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cmd_in),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cmd_out),
        .empty (cq_empty)
    );

    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .blank_color (blank_color),
        .cmd         (cmd_out),
        .cmd_empty   (cq_empty),
        .cmd_pop     (cq_pop),
        .res_full    (rq_full),
        .res_push    (rq_push),
        .res         (res_in),
        .init_busy   (init_busy)
    );

    tcw_queue #(
        .W     ($bits(tcw_pkg::res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (res_in),
        .full  (rq_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign cursor_index = res_out.cursor;
    assign cell_data    = res_out.data;

endmodule
